[hw/rtl/fnc_pkg.sv]
// Package for the float narrowing converter: format codes.
// No dependencies.
package fnc_pkg;
    localparam logic [1:0] FMT_HALF   = 2'd0;
    localparam logic [1:0] FMT_SINGLE = 2'd1;
    localparam logic [1:0] FMT_DOUBLE = 2'd2;
    localparam logic [1:0] FMT_SPARE  = 2'd3;
endpackage

[hw/rtl/fnc_to_single.sv]
// binary64 to binary32 rounding, two register stages with valid and stall.
// Depends on fnc_pkg.
module fnc_to_single (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  logic [63:0] in_bits,
    input  logic [1:0]  in_fmt,
    input  logic        in_last,
    output logic        out_vld,
    output logic [63:0] out_raw,
    output logic [31:0] out_single,
    output logic [1:0]  out_fmt,
    output logic        out_last
);
    import fnc_pkg::*;

    // stage A: classify and shift
    logic        a_vld_reg;
    logic [63:0] a_raw_reg;
    logic [1:0]  a_fmt_reg;
    logic        a_last_reg;
    logic [31:0] a_base_reg;
    logic        a_rnd_reg;
    logic        a_sat_reg;
    logic [31:0] a_base_next;
    logic        a_rnd_next;
    logic        a_sat_next;

    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] full;
    logic [52:0] sh;
    logic [52:0] rem;
    logic [52:0] hw;
    logic [5:0]  shift;
    logic [31:0] sgn;

    always_comb
    begin
        e = in_bits[62:52];
        m = in_bits[51:0];
        sgn = {in_bits[63], 31'd0};
        full = {1'b1, m};
        shift = 6'd0;
        sh = '0;
        rem = '0;
        hw = '0;
        a_base_next = sgn;
        a_rnd_next = 1'b0;
        a_sat_next = 1'b0;
        if (e == 11'h7ff)
        begin
            if (m == '0)
                a_base_next = sgn | 32'h7f800000;
            else
                a_base_next = sgn | 32'h7fc00000 | {10'd0, m[50:29]};
        end
        else if (e == 11'd0)
            a_base_next = sgn;
        else if (e >= 11'd1151)
            a_base_next = sgn | 32'h7f800000;
        else if (e > 11'd896)
        begin
            a_base_next = sgn | {1'b0, e[7:0] - 8'd128, m[51:29]};
            a_rnd_next = (m[28:0] > 29'h10000000) ||
                         (m[28:0] == 29'h10000000 && m[29]);
            a_sat_next = 1'b1;
        end
        else if (e >= 11'd873)
        begin
            shift = 6'(11'd926 - e);
            sh = full >> shift;
            rem = full & ((53'd1 << shift) - 53'd1);
            hw = 53'd1 << (shift - 6'd1);
            a_base_next = sgn | sh[31:0];
            a_rnd_next = (rem > hw) || (rem == hw && sh[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_raw_reg  <= in_bits;
            a_fmt_reg  <= in_fmt;
            a_last_reg <= in_last;
            a_base_reg <= a_base_next;
            a_rnd_reg  <= a_rnd_next;
            a_sat_reg  <= a_sat_next;
        end
    end

    // stage B: apply rounding increment
    logic        b_vld_reg;
    logic [31:0] b_single_next;
    logic [30:0] mag;

    always_comb
    begin
        mag = a_base_reg[30:0] + {30'd0, a_rnd_reg};
        if (a_sat_reg && mag > 31'h7f800000)
            mag = 31'h7f800000;
        b_single_next = {a_base_reg[31], mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (adv)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_raw    <= a_raw_reg;
            out_fmt    <= a_fmt_reg;
            out_last   <= a_last_reg;
            out_single <= b_single_next;
        end
    end

    assign out_vld = b_vld_reg;
endmodule

[hw/rtl/fnc_to_half.sv]
// binary32 to binary16 rounding and format select, two register stages.
// Depends on fnc_pkg.
module fnc_to_half (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  logic [63:0] in_raw,
    input  logic [31:0] in_single,
    input  logic [1:0]  in_fmt,
    input  logic        in_last,
    output logic        out_vld,
    output logic [63:0] out_bits,
    output logic        out_last
);
    import fnc_pkg::*;

    logic        c_vld_reg;
    logic [63:0] c_raw_reg;
    logic [31:0] c_single_reg;
    logic [1:0]  c_fmt_reg;
    logic        c_last_reg;
    logic [15:0] c_base_reg;
    logic        c_rnd_reg;
    logic [15:0] c_base_next;
    logic        c_rnd_next;

    logic [30:0] x;
    logic [15:0] sg;
    logic [23:0] mant;
    logic [4:0]  shift;
    logic [23:0] h;
    logic [23:0] rem;
    logic [23:0] hw;
    logic [17:0] hn;

    always_comb
    begin
        x = in_single[30:0];
        sg = {in_single[31], 15'd0};
        mant = {1'b1, x[22:0]};
        shift = 5'd0;
        h = '0;
        rem = '0;
        hw = '0;
        hn = '0;
        c_base_next = sg;
        c_rnd_next = 1'b0;
        if (x >= 31'h7f800000)
            c_base_next = sg | ((x > 31'h7f800000) ? 16'h7e00 : 16'h7c00);
        else if (x >= 31'h477ff000)
            c_base_next = sg | 16'h7c00;
        else if (x < 31'h38800000)
        begin
            if (x >= 31'h33000000)
            begin
                shift = 5'(8'd126 - x[30:23]);
                h = mant >> shift;
                rem = mant & ((24'd1 << shift) - 24'd1);
                hw = 24'd1 << (shift - 5'd1);
                c_base_next = sg | h[15:0];
                c_rnd_next = (rem > hw) || (rem == hw && h[0]);
            end
        end
        else
        begin
            hn = x[30:13] - 18'(112 << 10);
            c_base_next = sg | {1'b0, hn[14:0]};
            c_rnd_next = (x[12:0] > 13'h1000) || (x[12:0] == 13'h1000 && hn[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (adv)
            c_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_raw_reg    <= in_raw;
            c_single_reg <= in_single;
            c_fmt_reg    <= in_fmt;
            c_last_reg   <= in_last;
            c_base_reg   <= c_base_next;
            c_rnd_reg    <= c_rnd_next;
        end
    end

    logic        d_vld_reg;
    logic [63:0] d_bits_next;
    logic [14:0] hm;

    always_comb
    begin
        hm = c_base_reg[14:0] + {14'd0, c_rnd_reg};
        unique case (c_fmt_reg)
            FMT_HALF:   d_bits_next = {48'd0, c_base_reg[15], hm};
            FMT_SINGLE: d_bits_next = {32'd0, c_single_reg};
            default:    d_bits_next = c_raw_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (adv)
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_bits <= d_bits_next;
            out_last <= c_last_reg;
        end
    end

    assign out_vld = d_vld_reg;
endmodule

[hw/rtl/float_narrowing_converter_top.sv]
// Top level of the float narrowing converter: format register and pipeline.
// Depends on fnc_pkg, fnc_to_single and fnc_to_half.
//   channel  | handshake                   | payload
//   input    | in_valid / in_ready         | value_bits, last_in
//   output   | out_valid / out_ready       | packed_bits, last_out
//   config   | cfg_we                      | cfg_wdata (output_format)
// One word per cycle while the output is not stalled, through four register stages.
// The whole pipeline advances when the output stage is empty or taken.
// Reset empties every stage and sets the format to single precision.
module float_narrowing_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value_bits,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] packed_bits,
    output logic        last_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);
    import fnc_pkg::*;

    logic [1:0]  fmt_reg;
    logic        adv;
    logic        s_vld;
    logic [63:0] s_raw;
    logic [31:0] s_single;
    logic [1:0]  s_fmt;
    logic        s_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_SINGLE;
        else if (cfg_we)
            fmt_reg <= cfg_wdata;
    end

    assign adv = !out_valid || out_ready;
    assign in_ready = adv;

    fnc_to_single u_single (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_vld(in_valid), .in_bits(value_bits), .in_fmt(fmt_reg), .in_last(last_in),
        .out_vld(s_vld), .out_raw(s_raw), .out_single(s_single),
        .out_fmt(s_fmt), .out_last(s_last)
    );

    fnc_to_half u_half (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_vld(s_vld), .in_raw(s_raw), .in_single(s_single),
        .in_fmt(s_fmt), .in_last(s_last),
        .out_vld(out_valid), .out_bits(packed_bits), .out_last(last_out)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(packed_bits))
        else $error("stalled word changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready mismatch");
endmodule
